### rtl/lfr_pkg.sv
// Shared types and constants for the LRU frame replacer.
// Used by lfr_ctrl, lfr_datapath and lru_frame_replacer; depends on nothing.
`default_nettype none

package lfr_pkg;

   // List geometry.
   localparam int LIST_DEPTH    = 64;
   localparam int FRAME_ID_BITS = 8;
   localparam int CNT_BITS      = $clog2(LIST_DEPTH + 1);

   // Field widths fixed by the interface.
   localparam int KIND_BITS = 2;
   localparam int CAP_BITS  = 7;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

   typedef logic [FRAME_ID_BITS-1:0] frame_type;
   typedef logic [CNT_BITS-1:0]      count_type;
   typedef logic [CAP_BITS-1:0]      cap_type;
   typedef logic [LIST_DEPTH-1:0]    list_vec_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_VICTIM = 2'd0,
      KIND_PIN    = 2'd1,
      KIND_UNPIN  = 2'd2
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request word and its lookup results
      logic apply;     // update the list and load the result word
   } cmd_type;

endpackage

`default_nettype wire

### rtl/lfr_ctrl.sv
// Controller for the LRU frame replacer: request/result handshake sequencing.
// Depends on lfr_pkg.
`default_nettype none

module lfr_ctrl
   import lfr_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      // The result register can take a new word when it is empty or being drained.
      out_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.apply    = 1'b0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/lfr_datapath.sv
// Datapath for the LRU frame replacer: recency cells, count, capacity and result word.
// Depends on lfr_pkg; driven by commands from lfr_ctrl.
`default_nettype none

module lfr_datapath
   import lfr_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  cmd_type                  cmd,
   input  wire  [KIND_BITS-1:0]     req_kind,
   input  wire  [FRAME_ID_BITS-1:0] req_frame_id,
   input  wire                      csr_write,
   input  wire  [CAP_BITS-1:0]      csr_capacity,
   output logic                     rsp_found,
   output logic [FRAME_ID_BITS-1:0] rsp_victim_frame,
   output logic [CNT_BITS-1:0]      rsp_entry_count
);

   // Recency cells: position 0 is most recent; positions at or above count are stale.
   frame_type    cell_ff [LIST_DEPTH];
   frame_type    cell_in [LIST_DEPTH];
   count_type    count_ff, count_in;
   cap_type      capacity_ff;
   count_type    eff_cap;

   // Request word and lookup results captured at acceptance.
   kind_type     kind_ff;
   frame_type    frame_ff;
   list_vec_type remove_ff, remove_in;
   frame_type    tail_ff, tail_in;

   logic         found_ff, found_in;
   frame_type    victim_ff, victim_in;
   count_type    entry_count_ff;

   list_vec_type valid;
   list_vec_type match;

   // Lookup: compare every live cell, mark positions at or after the hit,
   // and pick out the least recent entry.
   always_comb begin
      tail_in = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         valid[i] = (CNT_BITS'(i) < count_ff);
         match[i] = valid[i] && (cell_ff[i] == req_frame_id);
      end
      for (int i = 0; i < LIST_DEPTH; i++) begin
         remove_in[i] = |(match & (list_vec_type'({LIST_DEPTH{1'b1}}) >> (LIST_DEPTH - 1 - i)));
         if (CNT_BITS'(i + 1) == count_ff) begin
            tail_in = tail_in | cell_ff[i];
         end
      end
   end

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_BITS'(1);
      end else if (int'(capacity_ff) > LIST_DEPTH) begin
         eff_cap = CNT_BITS'(LIST_DEPTH);
      end else begin
         eff_cap = CNT_BITS'(capacity_ff);
      end
   end

   // List update for the captured request.
   always_comb begin
      cell_in   = cell_ff;
      count_in  = count_ff;
      found_in  = 1'b0;
      victim_in = '0;
      case (kind_ff)
         KIND_VICTIM: begin
            if (count_ff != '0) begin
               count_in  = count_ff - CNT_BITS'(1);
               found_in  = 1'b1;
               victim_in = tail_ff;
            end
         end
         KIND_PIN: begin
            if (remove_ff[LIST_DEPTH-1]) begin
               for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                  if (remove_ff[i]) begin
                     cell_in[i] = cell_ff[i+1];
                  end
               end
               count_in = count_ff - CNT_BITS'(1);
            end
         end
         KIND_UNPIN: begin
            if (!remove_ff[LIST_DEPTH-1]) begin
               for (int i = 1; i < LIST_DEPTH; i++) begin
                  cell_in[i] = cell_ff[i-1];
               end
               cell_in[0] = frame_ff;
               // A full list drops its least recent entry off the end.
               if (count_ff < eff_cap) begin
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         capacity_ff <= CAP_RESET;
      end else begin
         if (cmd.apply) begin
            count_ff <= count_in;
         end
         if (csr_write) begin
            capacity_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= kind_type'(req_kind);
         frame_ff  <= req_frame_id;
         remove_ff <= remove_in;
         tail_ff   <= tail_in;
      end
      if (cmd.apply) begin
         cell_ff        <= cell_in;
         found_ff       <= found_in;
         victim_ff      <= victim_in;
         entry_count_ff <= count_in;
      end
   end

   assign rsp_found        = found_ff;
   assign rsp_victim_frame = victim_ff;
   assign rsp_entry_count  = entry_count_ff;

endmodule

`default_nettype wire

### rtl/lru_frame_replacer.sv
// Top level of the LRU frame replacer.
// Depends on lfr_pkg, lfr_ctrl and lfr_datapath.
`default_nettype none

// The replacer keeps up to 64 evictable frame ids in a recency list held in
// flip-flop cells, most recently unpinned first. Each request word (victim,
// pin or unpin) produces exactly one result word carrying found, the evicted
// frame and the entry count after the request. In the acceptance cycle
// every cell is compared with the frame id at once and the least recent
// entry is picked out; then, once the result register is empty or being
// drained, the list shifts in one step and the result register is loaded.
// No new request is taken until the previous one has been applied, but a
// finished result may wait in its register while the next request is
// accepted. An unpin of a frame already present leaves its place unchanged,
// and an unpin into a full list drops the least recent entry first.
// The capacity register is written through the csr port, which is always
// ready; write it only while no request is in flight. A capacity of zero acts
// as one, and lowering it below the current count does not trim the list.

module lru_frame_replacer
   import lfr_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire  [KIND_BITS-1:0]     req_kind,
   input  wire  [FRAME_ID_BITS-1:0] req_frame_id,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic                     rsp_found,
   output logic [FRAME_ID_BITS-1:0] rsp_victim_frame,
   output logic [CNT_BITS-1:0]      rsp_entry_count,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [CAP_BITS-1:0]      csr_capacity
);

   cmd_type cmd;

   // Configuration writes never need to wait.
   assign csr_ready = 1'b1;

   lfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_kind),
      .req_frame_id     (req_frame_id),
      .csr_write        (csr_valid && csr_ready),
      .csr_capacity     (csr_capacity),
      .rsp_found        (rsp_found),
      .rsp_victim_frame (rsp_victim_frame),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

`default_nettype wire
